/* rtl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, checked in and out of reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/pst_pkg.sv */
// types and constants of the three level priority stack buffer
package pst_pkg;

	localparam int NUM_STACKS = 3;

	localparam int STK_HIGH = 0;
	localparam int STK_MED  = 1;
	localparam int STK_LOW  = 2;

	localparam logic KIND_RECV = 1'b0;
	localparam logic KIND_PROC = 1'b1;

	localparam logic [1:0] PRIO_MED  = 2'd1;
	localparam logic [1:0] PRIO_HIGH = 2'd2;

	typedef struct packed {
		logic        kind;
		logic [15:0] packet_id;
		logic [1:0]  prio_level;
		logic [63:0] payload_word;
	} req_t;

	typedef struct packed {
		logic        ok;
		logic [15:0] out_id;
		logic [1:0]  out_prio;
		logic [63:0] out_payload;
		logic [7:0]  pending_high;
		logic [7:0]  pending_medium;
		logic [7:0]  pending_low;
		logic [31:0] received_count;
		logic [31:0] processed_count;
	} rsp_t;

	typedef struct packed {
		logic [15:0] id;
		logic [1:0]  prio;
		logic [63:0] payload;
	} entry_t;

	typedef struct packed {
		logic [NUM_STACKS-1:0] push;
		logic [NUM_STACKS-1:0] pop;
	} cmd_t;

endpackage

/* rtl/pst_cell.sv */
// one cell of the stack chain, holding one entry of each stack
module pst_cell (
	input  logic                                      clk,
	input  pst_pkg::cmd_t                             cmd,
	input  pst_pkg::entry_t [pst_pkg::NUM_STACKS-1:0] above,
	input  pst_pkg::entry_t [pst_pkg::NUM_STACKS-1:0] below,
	output pst_pkg::entry_t [pst_pkg::NUM_STACKS-1:0] q
);

	pst_pkg::entry_t [pst_pkg::NUM_STACKS-1:0] entry_q;

	always_ff @(posedge clk) begin
		for (int s = 0; s < pst_pkg::NUM_STACKS; s++) begin
			if (cmd.push[s]) begin
				entry_q[s] <= above[s];
			end else if (cmd.pop[s]) begin
				entry_q[s] <= below[s];
			end
		end
	end

	assign q = entry_q;

endmodule

/* rtl/pst_ctrl.sv */
// fill counts, transfer counters and push or pop decision
module pst_ctrl #(
	parameter int STACK_DEPTH = 128
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      accept,
	input  pst_pkg::req_t                             req,
	input  pst_pkg::entry_t [pst_pkg::NUM_STACKS-1:0] top,
	output pst_pkg::cmd_t                             cmd,
	output pst_pkg::entry_t                           new_entry,
	output pst_pkg::rsp_t                             result
);

	localparam int FW = $clog2(STACK_DEPTH + 1);

	logic [FW-1:0] fill_q [pst_pkg::NUM_STACKS];
	logic [FW-1:0] fill_d [pst_pkg::NUM_STACKS];
	logic [31:0]   rcv_q;
	logic [31:0]   prc_q;
	logic [1:0]    push_sel;
	logic [1:0]    pop_sel;
	logic          push_ok;
	logic          pop_ok;
	logic          do_push;
	logic          do_pop;

	always_comb begin
		unique case (req.prio_level)
			pst_pkg::PRIO_HIGH: push_sel = 2'(pst_pkg::STK_HIGH);
			pst_pkg::PRIO_MED:  push_sel = 2'(pst_pkg::STK_MED);
			default:            push_sel = 2'(pst_pkg::STK_LOW);
		endcase
	end

	always_comb begin
		pop_ok  = 1'b1;
		pop_sel = 2'(pst_pkg::STK_LOW);
		if (fill_q[pst_pkg::STK_HIGH] != '0) begin
			pop_sel = 2'(pst_pkg::STK_HIGH);
		end else if (fill_q[pst_pkg::STK_MED] != '0) begin
			pop_sel = 2'(pst_pkg::STK_MED);
		end else if (fill_q[pst_pkg::STK_LOW] == '0) begin
			pop_ok = 1'b0;
		end
	end

	assign push_ok = fill_q[push_sel] < FW'(STACK_DEPTH);
	assign do_push = (req.kind == pst_pkg::KIND_RECV) && push_ok;
	assign do_pop  = (req.kind == pst_pkg::KIND_PROC) && pop_ok;

	assign new_entry.id      = req.packet_id;
	assign new_entry.prio    = req.prio_level;
	assign new_entry.payload = req.payload_word;

	always_comb begin
		cmd.push = '0;
		cmd.pop  = '0;
		for (int s = 0; s < pst_pkg::NUM_STACKS; s++) begin
			fill_d[s] = fill_q[s];
			if (do_push && (push_sel == 2'(s))) begin
				cmd.push[s] = accept;
				fill_d[s]   = fill_q[s] + FW'(1);
			end
			if (do_pop && (pop_sel == 2'(s))) begin
				cmd.pop[s] = accept;
				fill_d[s]  = fill_q[s] - FW'(1);
			end
		end
	end

	always_comb begin
		result                 = '0;
		result.ok              = do_push || do_pop;
		if (do_pop) begin
			result.out_id      = top[pop_sel].id;
			result.out_prio    = top[pop_sel].prio;
			result.out_payload = top[pop_sel].payload;
		end
		result.pending_high    = 8'(fill_d[pst_pkg::STK_HIGH]);
		result.pending_medium  = 8'(fill_d[pst_pkg::STK_MED]);
		result.pending_low     = 8'(fill_d[pst_pkg::STK_LOW]);
		result.received_count  = rcv_q + 32'(do_push);
		result.processed_count = prc_q + 32'(do_pop);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < pst_pkg::NUM_STACKS; s++) begin
				fill_q[s] <= '0;
			end
			rcv_q <= '0;
			prc_q <= '0;
		end else if (accept) begin
			for (int s = 0; s < pst_pkg::NUM_STACKS; s++) begin
				fill_q[s] <= fill_d[s];
			end
			rcv_q <= result.received_count;
			prc_q <= result.processed_count;
		end
	end

endmodule

/* rtl/three_level_priority_stack_buffer.sv */
// top level of the three level priority stack buffer
//
// channel  handshake               payload           role
// req      req_valid / req_ready   pst_pkg::req_t    receive or process command
// rsp      rsp_valid / rsp_ready   pst_pkg::rsp_t    one result per command
//
// one command per cycle while req_ready is high; its result is registered and shows the next cycle
// the stacks are a chain of cells whose top entries sit in the first cell,
// so a push or pop shifts every cell of one stack in the same cycle
// req_ready is high while the result register is empty or being drained
// reset clears fills and counters at once; stored entries are not cleared
module three_level_priority_stack_buffer #(
	parameter int STACK_DEPTH = 128
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  pst_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output pst_pkg::rsp_t rsp
);

	pst_pkg::entry_t [pst_pkg::NUM_STACKS-1:0] cell_q [STACK_DEPTH];
	pst_pkg::entry_t                           new_entry;
	pst_pkg::cmd_t                             cmd;
	pst_pkg::rsp_t                             result;
	pst_pkg::rsp_t                             rsp_q;
	logic                                      rsp_valid_q;
	logic                                      accept;

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;

	pst_ctrl #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.req      (req),
		.top      (cell_q[0]),
		.cmd      (cmd),
		.new_entry(new_entry),
		.result   (result)
	);

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		pst_pkg::entry_t [pst_pkg::NUM_STACKS-1:0] above;
		pst_pkg::entry_t [pst_pkg::NUM_STACKS-1:0] below;

		if (i == 0) begin : g_first
			assign above = {pst_pkg::NUM_STACKS{new_entry}};
		end else begin : g_mid
			assign above = cell_q[i-1];
		end

		if (i == STACK_DEPTH - 1) begin : g_last
			assign below = '0;
		end else begin : g_inner
			assign below = cell_q[i+1];
		end

		pst_cell u_cell (
			.clk  (clk),
			.cmd  (cmd),
			.above(above),
			.below(below),
			.q    (cell_q[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* rtl/pst_checker.sv */
// port level checks of the three level priority stack buffer
`include "assert_macros.svh"

module pst_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input pst_pkg::rsp_t rsp
);

	logic req_xfer;
	logic rsp_stall;
	logic rsp_fail;
	logic failed_has_no_entry;

	assign req_xfer            = req_valid && req_ready;
	assign rsp_stall           = rsp_valid && !rsp_ready;
	assign rsp_fail            = rsp_valid && !rsp.ok;
	assign failed_has_no_entry = (rsp.out_id == '0) && (rsp.out_prio == '0)
		&& (rsp.out_payload == '0);

	// a stalled result holds
	`ASSERT_CLK(a_rsp_hold, clk, arst_n, rsp_stall |=> rsp_valid && $stable(rsp), "stalled result changed")

	// a failed push or pop carries no entry
	`ASSERT_CLK(a_fail_zero, clk, arst_n, rsp_fail |-> failed_has_no_entry, "failed result carries entry data")

	// no result without a request transfer or a pending result the cycle before
	`ASSERT_CLK(a_no_invent, clk, arst_n, !$past(req_xfer || rsp_valid) |-> !rsp_valid, "result without transfer")

	// an empty result register never blocks requests
	`ASSERT_ALWAYS(a_ready_empty, clk, !rsp_valid |-> req_ready, "request stalled with no result pending")

endmodule

bind three_level_priority_stack_buffer pst_checker u_pst_checker (.*);
